@@ src/vector3_normalize_fixed_core_macros.svh @@
// Assertion helpers shared by the vector normalization RTL.
`ifndef VECTOR3_NORMALIZE_FIXED_CORE_MACROS_SVH
`define VECTOR3_NORMALIZE_FIXED_CORE_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define VNF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vector normalize check failed");

// Next-cycle implication, checked while out of reset.
`define VNF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vector normalize check failed");

`endif

@@ src/vnf_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vnf_pkg
// Shared constants and types of the fixed-point vector normalizer.
// ============================================================================
package vnf_pkg;

    // The squared length is scaled by 2^LEN_SHIFT before the square root,
    // which gives the length LEN_HALF fraction bits more than the input.
    localparam int LEN_SHIFT = 16;
    localparam int LEN_HALF  = 8;

    // Per-item sign and zero information that travels beside the data.
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic neg_z;
        logic zero;
    } vnf_flags_t;

    localparam int FLAGS_W = $bits(vnf_flags_t);

endpackage

@@ src/vnf_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vnf_front
// Magnitudes, squares, sum of squares and a pipelined integer square root.
// ============================================================================
module vnf_front
    import vnf_pkg::*;
#(
    parameter int IN_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [IN_WIDTH-1:0]          in_x,
    input  logic [IN_WIDTH-1:0]          in_y,
    input  logic [IN_WIDTH-1:0]          in_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [IN_WIDTH-1:0]          out_mag_x,
    output logic [IN_WIDTH-1:0]          out_mag_y,
    output logic [IN_WIDTH-1:0]          out_mag_z,
    output vnf_flags_t                   out_flags,
    output logic [IN_WIDTH+LEN_HALF-1:0] out_root
);

    localparam int SW = 2 * IN_WIDTH;
    localparam int VW = SW + LEN_SHIFT;
    localparam int NB = IN_WIDTH + LEN_HALF;
    localparam int RW = NB + 2;

    logic                en;
    logic [IN_WIDTH-1:0] in_c [3];
    logic [IN_WIDTH-1:0] mag_c [3];
    logic [2:0]          neg_c;

    logic                va_reg;
    logic [IN_WIDTH-1:0] mag_a_reg [3];
    logic [2:0]          neg_a_reg;

    logic                vb_reg;
    logic [SW-1:0]       sq_b_reg [3];
    logic [IN_WIDTH-1:0] mag_b_reg [3];
    logic [2:0]          neg_b_reg;

    logic                vld_reg  [NB+1];
    logic [VW-1:0]       val_reg  [NB+1];
    logic [RW-1:0]       rem_reg  [NB+1];
    logic [NB-1:0]       root_reg [NB+1];
    logic [IN_WIDTH-1:0] mag_reg  [NB+1][3];
    vnf_flags_t          flg_reg  [NB+1];

    logic [SW-1:0]       sum;

    // The whole pipe moves together; it only holds when its last slot is blocked.
    assign en       = !vld_reg[NB] || out_ready;
    assign in_ready = en;

    assign in_c[0] = in_x;
    assign in_c[1] = in_y;
    assign in_c[2] = in_z;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            neg_c[c] = in_c[c][IN_WIDTH-1];
            mag_c[c] = neg_c[c] ? (~in_c[c] + 1'b1) : in_c[c];
        end
    end

    assign sum = sq_b_reg[0] + sq_b_reg[1] + sq_b_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg     <= 1'b0;
            vb_reg     <= 1'b0;
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            va_reg     <= in_valid;
            vb_reg     <= va_reg;
            vld_reg[0] <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_a_reg <= neg_c;
            neg_b_reg <= neg_a_reg;
            for (int c = 0; c < 3; c++)
            begin
                mag_a_reg[c]  <= mag_c[c];
                sq_b_reg[c]   <= SW'(mag_a_reg[c]) * SW'(mag_a_reg[c]);
                mag_b_reg[c]  <= mag_a_reg[c];
                mag_reg[0][c] <= mag_b_reg[c];
            end
            val_reg[0]  <= {sum, {LEN_SHIFT{1'b0}}};
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            flg_reg[0]  <= '{neg_x: neg_b_reg[0], neg_y: neg_b_reg[1],
                             neg_z: neg_b_reg[2], zero: (sum == '0)};
        end
    end

    // One result bit of the square root per stage, restoring method.
    genvar k;
    generate
        for (k = 0; k < NB; k++)
        begin : g_sqrt
            logic [RW-1:0] rem_sh;
            logic [RW-1:0] trial;
            logic          take;

            assign rem_sh = {rem_reg[k][RW-3:0], val_reg[k][VW-1 -: 2]};
            assign trial  = {root_reg[k], 2'b01};
            assign take   = (rem_sh >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k+1] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k+1] <= vld_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    val_reg[k+1]  <= val_reg[k] << 2;
                    rem_reg[k+1]  <= take ? (rem_sh - trial) : rem_sh;
                    root_reg[k+1] <= {root_reg[k][NB-2:0], take};
                    flg_reg[k+1]  <= flg_reg[k];
                    for (int c = 0; c < 3; c++)
                    begin
                        mag_reg[k+1][c] <= mag_reg[k][c];
                    end
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NB];
    assign out_mag_x = mag_reg[NB][0];
    assign out_mag_y = mag_reg[NB][1];
    assign out_mag_z = mag_reg[NB][2];
    assign out_flags = flg_reg[NB];
    assign out_root  = root_reg[NB];

endmodule

@@ src/vnf_queue.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vnf_queue
// Small register FIFO that separates the root pipe from the divider pipe.
// ============================================================================
module vnf_queue
    import vnf_pkg::*;
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ src/vnf_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vnf_back
// Three pipelined restoring dividers, clamp, sign and the output register.
// ============================================================================
module vnf_back
    import vnf_pkg::*;
#(
    parameter int IN_WIDTH      = 16,
    parameter int OUT_FRAC_BITS = 14
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [IN_WIDTH-1:0]          in_mag_x,
    input  logic [IN_WIDTH-1:0]          in_mag_y,
    input  logic [IN_WIDTH-1:0]          in_mag_z,
    input  vnf_flags_t                   in_flags,
    input  logic [IN_WIDTH+LEN_HALF-1:0] in_root,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [OUT_FRAC_BITS+1:0]     out_x,
    output logic [OUT_FRAC_BITS+1:0]     out_y,
    output logic [OUT_FRAC_BITS+1:0]     out_z,
    output logic                         out_zero
);

    localparam int NB = IN_WIDTH + LEN_HALF;
    localparam int QB = OUT_FRAC_BITS + 1;
    localparam int DW = NB + 1;
    localparam int OW = OUT_FRAC_BITS + 2;

    localparam logic [QB-1:0] ONE = QB'(1) << OUT_FRAC_BITS;

    logic                en;
    logic [IN_WIDTH-1:0] in_m [3];
    logic                in_n [3];

    logic                vld_reg [QB+1];
    logic [NB-1:0]       den_reg [QB+1];
    logic [DW-1:0]       rem_reg [QB+1][3];
    logic [QB-1:0]       quo_reg [QB+1][3];
    vnf_flags_t          flg_reg [QB+1];

    logic                out_valid_reg;
    logic [OW-1:0]       res_reg [3];
    logic                zero_reg;
    logic [OW-1:0]       res_c   [3];

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign in_m[0] = in_mag_x;
    assign in_m[1] = in_mag_y;
    assign in_m[2] = in_mag_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    // The low numerator bits are all zero, so the division starts from the
    // magnitude shifted up and then brings in zeros one bit per stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= in_root;
            flg_reg[0] <= in_flags;
            for (int c = 0; c < 3; c++)
            begin
                rem_reg[0][c] <= DW'(in_m[c]) << (LEN_HALF - 1);
                quo_reg[0][c] <= '0;
            end
        end
    end

    genvar k;
    generate
        for (k = 0; k < QB; k++)
        begin : g_div
            logic [DW-1:0] rs   [3];
            logic          take [3];

            always_comb
            begin
                for (int c = 0; c < 3; c++)
                begin
                    rs[c]   = {rem_reg[k][c][DW-2:0], 1'b0};
                    take[c] = (rs[c] >= {1'b0, den_reg[k]});
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k+1] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k+1] <= vld_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[k+1] <= den_reg[k];
                    flg_reg[k+1] <= flg_reg[k];
                    for (int c = 0; c < 3; c++)
                    begin
                        rem_reg[k+1][c] <= take[c] ? (rs[c] - {1'b0, den_reg[k]}) : rs[c];
                        quo_reg[k+1][c] <= {quo_reg[k][c][QB-2:0], take[c]};
                    end
                end
            end
        end
    endgenerate

    assign in_n[0] = flg_reg[QB].neg_x;
    assign in_n[1] = flg_reg[QB].neg_y;
    assign in_n[2] = flg_reg[QB].neg_z;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            res_c[c] = OW'((quo_reg[QB][c] > ONE) ? ONE : quo_reg[QB][c]);
            if (flg_reg[QB].zero)
            begin
                res_c[c] = '0;
            end
            else if (in_n[c])
            begin
                res_c[c] = ~res_c[c] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg <= flg_reg[QB].zero;
            for (int c = 0; c < 3; c++)
            begin
                res_reg[c] <= res_c[c];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = res_reg[0];
    assign out_y     = res_reg[1];
    assign out_z     = res_reg[2];
    assign out_zero  = zero_reg;

endmodule

@@ src/vector3_normalize_fixed_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vector3_normalize_fixed_core
// Normalizes a signed Q8.8 three-component vector to a signed Q1.14 unit vector.
// ============================================================================
// The s_axis channel takes one vector per transfer: x, y and z in tdata.
// The m_axis channel gives one result per input: the unit components in
// tdata and a zero-vector flag in tuser. A two-component vector is sent
// with z at zero; a zero vector returns zeros with the flag set.
// Throughput is one vector per cycle while nothing stalls. On its way
// a vector passes the registers for magnitudes, squares and sum,
// IN_WIDTH + 8 square root stages, an entry of the queue, the divider
// input register, OUT_FRAC_BITS + 1 divider stages and the output
// register.
// The square root and the dividers each resolve one bit per stage.
// A stalled receiver freezes the divider pipe and the output register;
// the root pipe keeps going until the queue between them is full, and
// only then s_axis_tready drops. Reset empties both pipes and the queue.
// ============================================================================
`include "vector3_normalize_fixed_core_macros.svh"

module vector3_normalize_fixed_core
    import vnf_pkg::*;
#(
    parameter int IN_WIDTH      = 16,
    parameter int OUT_FRAC_BITS = 14
)
(
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           s_axis_tvalid,
    output logic                                           s_axis_tready,
    // in_x, in_y, in_z
    input  logic [((3*IN_WIDTH+7)/8)*8-1:0]                s_axis_tdata,
    output logic                                           m_axis_tvalid,
    input  logic                                           m_axis_tready,
    // unit_x, unit_y, unit_z
    output logic [((3*(OUT_FRAC_BITS+2)+7)/8)*8-1:0]       m_axis_tdata,
    // was_zero
    output logic                                           m_axis_tuser
);

    localparam int OW    = OUT_FRAC_BITS + 2;
    localparam int OD_W  = ((3 * OW + 7) / 8) * 8;
    localparam int NB    = IN_WIDTH + LEN_HALF;
    localparam int QW    = FLAGS_W + 3 * IN_WIDTH + NB;
    localparam int ONE_I = 1 << OUT_FRAC_BITS;

    logic                f_valid, f_ready;
    logic [IN_WIDTH-1:0] f_mag_x, f_mag_y, f_mag_z;
    vnf_flags_t          f_flags;
    logic [NB-1:0]       f_root;

    logic                q_valid, q_ready;
    logic [QW-1:0]       q_data;
    logic [IN_WIDTH-1:0] b_mag_x, b_mag_y, b_mag_z;
    vnf_flags_t          b_flags;
    logic [NB-1:0]       b_root;

    logic [OW-1:0]       ux, uy, uz;
    logic                ux_ok, uy_ok, uz_ok;

    vnf_front #(
        .IN_WIDTH (IN_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_x      (s_axis_tdata[IN_WIDTH-1:0]),
        .in_y      (s_axis_tdata[2*IN_WIDTH-1:IN_WIDTH]),
        .in_z      (s_axis_tdata[3*IN_WIDTH-1:2*IN_WIDTH]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_mag_x (f_mag_x),
        .out_mag_y (f_mag_y),
        .out_mag_z (f_mag_z),
        .out_flags (f_flags),
        .out_root  (f_root)
    );

    vnf_queue #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_flags, f_mag_z, f_mag_y, f_mag_x, f_root}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    assign {b_flags, b_mag_z, b_mag_y, b_mag_x, b_root} = q_data;

    vnf_back #(
        .IN_WIDTH      (IN_WIDTH),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_mag_x  (b_mag_x),
        .in_mag_y  (b_mag_y),
        .in_mag_z  (b_mag_z),
        .in_flags  (b_flags),
        .in_root   (b_root),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_x     (ux),
        .out_y     (uy),
        .out_z     (uz),
        .out_zero  (m_axis_tuser)
    );

    assign m_axis_tdata = OD_W'({uz, uy, ux});

    assign ux_ok = ($signed(ux) <= ONE_I) && ($signed(ux) >= -ONE_I);
    assign uy_ok = ($signed(uy) <= ONE_I) && ($signed(uy) >= -ONE_I);
    assign uz_ok = ($signed(uz) <= ONE_I) && ($signed(uz) >= -ONE_I);

    // A zero vector must come out as all zeros.
    `VNF_ASSERT_NOW(a_zero_out, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)

    // A nonzero vector always has at least one nonzero component.
    `VNF_ASSERT_NOW(a_nonzero_out, m_axis_tvalid && !m_axis_tuser, (ux | uy | uz) != '0)

    // Every component stays within plus or minus one.
    `VNF_ASSERT_NOW(a_unit_range, m_axis_tvalid, ux_ok && uy_ok && uz_ok)

    // A root blocked by a full queue is held in the front pipe.
    `VNF_ASSERT_NEXT(a_front_hold, f_valid && !f_ready, f_valid)

endmodule
